/* rtl/core/ascii_coord_frame_stepper_driver_macros.svh */
// assertion macros shared by the checker of the ascii frame stepper driver
// no dependencies; included by files that assert
`ifndef ASCII_COORD_FRAME_STEPPER_DRIVER_MACROS_SVH
`define ASCII_COORD_FRAME_STEPPER_DRIVER_MACROS_SVH

// condition must hold at every edge outside reset
`define ACFSD_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("acfsd assertion failed");

// same-cycle implication
`define ACFSD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acfsd assertion failed");

// next-cycle implication
`define ACFSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acfsd assertion failed");

`endif

/* rtl/core/acfsd_pkg.sv */
// shared types, character codes and helpers for the ascii frame stepper driver
// no dependencies
package acfsd_pkg;

  localparam int unsigned FRAME_LEN = 10;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned STEP_W    = 10;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_OVERRUN = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_OVERRUN = 2'd1,
    FAULT_DIGITS  = 2'd2
  } fault_t;

  // outcome of one byte at the frame assembler
  typedef struct packed {
    logic              load;
    logic              bad_digits;
    logic [STEP_W-1:0] x_steps;
    logic              x_minus;
    logic [STEP_W-1:0] y_steps;
    logic              y_minus;
  } frame_load_t;

  // per-axis view after the current request
  typedef struct packed {
    logic              pulse;
    logic              reverse;
    logic [STEP_W-1:0] left;
  } axis_view_t;

  typedef struct packed {
    logic              x_pulse;
    logic              y_pulse;
    logic              x_reverse;
    logic              y_reverse;
    logic              drive_enable_pin;
    logic [STEP_W-1:0] x_left;
    logic [STEP_W-1:0] y_left;
    logic              frame_accepted;
    logic [1:0]        fault;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return d <= 8'd9;
  endfunction

  // three ascii digits known to be valid, most significant first
  function automatic logic [STEP_W-1:0] three_digits(input logic [7:0] h,
                                                     input logic [7:0] t,
                                                     input logic [7:0] u);
    logic [STEP_W-1:0] hv;
    logic [STEP_W-1:0] tv;
    logic [STEP_W-1:0] uv;
    hv = STEP_W'(h[3:0]);
    tv = STEP_W'(t[3:0]);
    uv = STEP_W'(u[3:0]);
    return STEP_W'(hv * STEP_W'(100)) + STEP_W'(tv * STEP_W'(10)) + uv;
  endfunction

endpackage

/* rtl/core/acfsd_in_if.sv */
// request channel of the ascii frame stepper driver: command and received byte
// no dependencies
interface acfsd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, cmd, rx_byte, input ready);
  modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

/* rtl/core/acfsd_out_if.sv */
// result channel of the ascii frame stepper driver: pulses, levels and status
// no dependencies
interface acfsd_out_if;
  logic       valid;
  logic       ready;
  logic       x_pulse;
  logic       y_pulse;
  logic       x_reverse;
  logic       y_reverse;
  logic       drive_enable_pin;
  logic [9:0] x_left;
  logic [9:0] y_left;
  logic       frame_accepted;
  logic [1:0] fault;

  modport source (output valid, x_pulse, y_pulse, x_reverse, y_reverse, drive_enable_pin,
                  x_left, y_left, frame_accepted, fault, input ready);
  modport sink   (input valid, x_pulse, y_pulse, x_reverse, y_reverse, drive_enable_pin,
                  x_left, y_left, frame_accepted, fault, output ready);
endinterface

/* rtl/core/acfsd_frame.sv */
// frame assembler: stores bytes of a ten-byte coordinate frame and decodes it
// depends on acfsd_pkg
module acfsd_frame import acfsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  rx_byte,
  output frame_load_t frame
);

  logic [POS_W-1:0] frame_pos;
  logic [POS_W-1:0] frame_pos_next;
  logic [7:0]       frame_bytes [FRAME_LEN];
  logic [POS_W-1:0] pos;
  logic [7:0]       first_byte;
  logic             digits_ok;
  logic             y_ok;

  // positions past the end count as the start
  assign pos        = (frame_pos > POS_LAST) ? '0 : frame_pos;
  assign first_byte = (pos == '0) ? rx_byte : frame_bytes[0];

  assign digits_ok = is_digit(frame_bytes[2]) & is_digit(frame_bytes[3]) &
                     is_digit(frame_bytes[4]) & is_digit(frame_bytes[7]) &
                     is_digit(frame_bytes[8]) & is_digit(rx_byte);
  assign y_ok      = (frame_bytes[5] == CH_Y);

  always_comb begin
    frame = '0;
    if (pos == POS_LAST) begin
      frame_pos_next   = '0;
      frame.load       = y_ok & digits_ok;
      frame.bad_digits = y_ok & ~digits_ok;
    end else if (first_byte != CH_X) begin
      frame_pos_next = '0;
    end else begin
      frame_pos_next = pos + POS_W'(1);
    end
    if (frame_bytes[1] == CH_MINUS || frame_bytes[1] == CH_PLUS) begin
      frame.x_steps = three_digits(frame_bytes[2], frame_bytes[3], frame_bytes[4]);
    end
    frame.x_minus = (frame_bytes[1] == CH_MINUS);
    if (frame_bytes[6] == CH_MINUS || frame_bytes[6] == CH_PLUS) begin
      frame.y_steps = three_digits(frame_bytes[7], frame_bytes[8], rx_byte);
    end
    frame.y_minus = (frame_bytes[6] == CH_MINUS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos <= '0;
    end else if (take) begin
      frame_pos <= frame_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame_bytes[pos] <= rx_byte;
    end
  end

endmodule

/* rtl/core/acfsd_axis.sv */
// one stepper axis: pending step count, direction flag and pulse decision
// depends on acfsd_pkg
module acfsd_axis import acfsd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic              load,
  input  logic [STEP_W-1:0] load_steps,
  input  logic              load_minus,
  output axis_view_t        view
);

  logic [STEP_W-1:0] steps;
  logic [STEP_W-1:0] steps_next;
  logic              minus;
  logic              minus_next;
  logic              pulse;

  assign pulse = tick & (steps != '0);

  always_comb begin
    steps_next = steps;
    minus_next = minus;
    if (load) begin
      steps_next = load_steps;
      minus_next = load_minus;
    end else if (pulse) begin
      steps_next = steps - STEP_W'(1);
    end
  end

  assign view.pulse   = pulse;
  assign view.reverse = minus_next;
  assign view.left    = steps_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      minus <= 1'b0;
    end else begin
      steps <= steps_next;
      minus <= minus_next;
    end
  end

endmodule

/* rtl/core/ascii_coord_frame_stepper_driver.sv */
// path: the input register loads a request at the edge that accepts it, and the request moves
// on into the result register once that register is free or being emptied
// throughput: one request per cycle, sustained while the result side keeps taking results
// the rate is set by the single pass from the input register through the frame decode and
// axis counters into the result register
// reset (rst, synchronous, active high) clears frame position, counts, signs, enable and fault
module ascii_coord_frame_stepper_driver import acfsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  acfsd_in_if.sink    request,
  acfsd_out_if.source result
);

  // input register
  logic       s1_valid;
  logic [1:0] s1_cmd;
  logic [7:0] s1_byte;

  // result register
  logic    res_valid;
  result_t res;
  result_t res_next;

  // block state outside the sub-units
  logic   enable_level;
  logic   enable_level_next;
  fault_t last_fault;
  fault_t last_fault_next;

  logic        advance;
  logic        req_take;
  logic        is_byte;
  logic        is_tick;
  frame_load_t frame;
  axis_view_t  x_view;
  axis_view_t  y_view;

  // the held request moves on when the result register is free or being emptied
  assign advance       = s1_valid & (~res_valid | result.ready);
  assign request.ready = ~s1_valid | advance;
  assign req_take      = request.valid & request.ready;

  // command decode
  always_comb begin
    is_byte           = 1'b0;
    is_tick           = 1'b0;
    enable_level_next = enable_level;
    last_fault_next   = last_fault;
    unique case (cmd_t'(s1_cmd))
      CMD_BYTE: begin
        is_byte           = 1'b1;
        enable_level_next = 1'b1;
        if (frame.bad_digits) begin
          last_fault_next = FAULT_DIGITS;
        end
      end
      CMD_OVERRUN: begin
        enable_level_next = 1'b1;
        last_fault_next   = FAULT_OVERRUN;
      end
      CMD_TICK: begin
        is_tick           = 1'b1;
        enable_level_next = 1'b0;
      end
      default: begin
        // spare code leaves everything as it is
      end
    endcase
  end

  acfsd_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .take    (advance & is_byte),
    .rx_byte (s1_byte),
    .frame   (frame)
  );

  acfsd_axis u_x_axis (
    .clk        (clk),
    .rst        (rst),
    .tick       (advance & is_tick),
    .load       (advance & is_byte & frame.load),
    .load_steps (frame.x_steps),
    .load_minus (frame.x_minus),
    .view       (x_view)
  );

  acfsd_axis u_y_axis (
    .clk        (clk),
    .rst        (rst),
    .tick       (advance & is_tick),
    .load       (advance & is_byte & frame.load),
    .load_steps (frame.y_steps),
    .load_minus (frame.y_minus),
    .view       (y_view)
  );

  // result fields show the state after this request
  always_comb begin
    res_next.x_pulse          = x_view.pulse;
    res_next.y_pulse          = y_view.pulse;
    res_next.x_reverse        = x_view.reverse;
    res_next.y_reverse        = y_view.reverse;
    res_next.drive_enable_pin = enable_level_next;
    res_next.x_left           = x_view.left;
    res_next.y_left           = y_view.left;
    res_next.frame_accepted   = is_byte & frame.load;
    res_next.fault            = last_fault_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      res_valid    <= 1'b0;
      enable_level <= 1'b0;
      last_fault   <= FAULT_NONE;
    end else begin
      if (req_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        res_valid    <= 1'b1;
        enable_level <= enable_level_next;
        last_fault   <= last_fault_next;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_cmd  <= request.cmd;
      s1_byte <= request.rx_byte;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.valid            = res_valid;
  assign result.x_pulse          = res.x_pulse;
  assign result.y_pulse          = res.y_pulse;
  assign result.x_reverse        = res.x_reverse;
  assign result.y_reverse        = res.y_reverse;
  assign result.drive_enable_pin = res.drive_enable_pin;
  assign result.x_left           = res.x_left;
  assign result.y_left           = res.y_left;
  assign result.frame_accepted   = res.frame_accepted;
  assign result.fault            = res.fault;

endmodule

/* rtl/core/acfsd_checker.sv */
// port-level checker for the ascii frame stepper driver, bound to the top level
// depends on the macros header
`include "ascii_coord_frame_stepper_driver_macros.svh"

module acfsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       x_pulse,
  input logic       y_pulse,
  input logic       drive_enable_pin,
  input logic [9:0] x_left,
  input logic [9:0] y_left,
  input logic       frame_accepted
);

  // a step pulse only comes from a tick, which drops the enable line
  `ACFSD_ASSERT_IMPL(a_pulse_disabled, clk, rst, res_valid && (x_pulse || y_pulse), !drive_enable_pin)
  // an accepted frame comes from a byte: enable high and no pulses
  `ACFSD_ASSERT_IMPL(a_frame_quiet, clk, rst, res_valid && frame_accepted, drive_enable_pin && !x_pulse && !y_pulse)
  // counts come from three decimal digits
  `ACFSD_ASSERT_ALWAYS(a_count_range, clk, rst, !res_valid || (x_left <= 10'd999 && y_left <= 10'd999))
  // a stalled result holds
  `ACFSD_ASSERT_NEXT(a_stall_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(x_left) && $stable(y_left))

endmodule

bind ascii_coord_frame_stepper_driver acfsd_checker u_acfsd_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (result.valid),
  .res_ready        (result.ready),
  .x_pulse          (result.x_pulse),
  .y_pulse          (result.y_pulse),
  .drive_enable_pin (result.drive_enable_pin),
  .x_left           (result.x_left),
  .y_left           (result.y_left),
  .frame_accepted   (result.frame_accepted)
);

/* tb/sv/acfsd_status_checker.sv */
// checker for the ascii frame stepper driver: watches both channels and predicts every status
// depends on acfsd_pkg, acfsd_in_if and acfsd_out_if
module acfsd_status_checker import acfsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  acfsd_in_if         request,
  acfsd_out_if        result,
  output int unsigned mismatches,
  output int unsigned results_seen
);

  // predicted block state
  logic [POS_W-1:0]  frame_at;
  logic [7:0]        frame_mem [FRAME_LEN];
  logic [STEP_W-1:0] x_count;
  logic [STEP_W-1:0] y_count;
  logic              x_minus;
  logic              y_minus;
  logic              en_level;
  fault_t            fault_level;

  result_t status_queue [$];
  result_t want_status;

  initial begin
    mismatches   = 0;
    results_seen = 0;
  end

  function automatic logic ascii_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_ZERO + 8'd9);
  endfunction

  // sign at position at, digits in the three positions after it
  function automatic void load_axis(input int unsigned at, output logic [STEP_W-1:0] steps,
                                    output logic minus);
    logic [7:0] sg;
    sg = frame_mem[at];
    if (sg == CH_MINUS || sg == CH_PLUS) begin
      steps = STEP_W'(frame_mem[at+1] - CH_ZERO) * STEP_W'(100)
            + STEP_W'(frame_mem[at+2] - CH_ZERO) * STEP_W'(10)
            + STEP_W'(frame_mem[at+3] - CH_ZERO);
      minus = (sg == CH_MINUS);
    end else begin
      // unknown sign clears the axis
      steps = '0;
      minus = 1'b0;
    end
  endfunction

  function automatic result_t predict_status(input logic [1:0] c, input logic [7:0] b);
    result_t          r;
    logic [POS_W-1:0] p;
    logic             digits_ok;
    int unsigned      i;
    r = '0;
    case (c)
      CMD_BYTE: begin
        en_level = 1'b1;
        p = (frame_at > POS_LAST) ? '0 : frame_at;
        frame_mem[p] = b;
        if (p != POS_LAST) begin
          frame_at = (frame_mem[0] == CH_X) ? p + 1'b1 : '0;
        end else begin
          frame_at = '0;
          if (frame_mem[5] == CH_Y) begin
            digits_ok = 1'b1;
            for (i = 2; i <= 4; i++) begin
              if (!ascii_digit(frame_mem[i]) || !ascii_digit(frame_mem[i+5])) digits_ok = 1'b0;
            end
            if (!digits_ok) begin
              fault_level = FAULT_DIGITS;
            end else begin
              load_axis(1, x_count, x_minus);
              load_axis(6, y_count, y_minus);
              r.frame_accepted = 1'b1;
            end
          end
        end
      end
      CMD_OVERRUN: begin
        en_level    = 1'b1;
        fault_level = FAULT_OVERRUN;
      end
      CMD_TICK: begin
        en_level = 1'b0;
        if (x_count != 0) begin
          r.x_pulse = 1'b1;
          x_count--;
        end
        if (y_count != 0) begin
          r.y_pulse = 1'b1;
          y_count--;
        end
      end
      default: ;
    endcase
    r.x_reverse        = x_minus;
    r.y_reverse        = y_minus;
    r.drive_enable_pin = en_level;
    r.x_left           = x_count;
    r.y_left           = y_count;
    r.fault            = fault_level;
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_at    <= '0;
      x_count     <= '0;
      y_count     <= '0;
      x_minus     <= 1'b0;
      y_minus     <= 1'b0;
      en_level    <= 1'b0;
      fault_level <= FAULT_NONE;
      foreach (frame_mem[k]) frame_mem[k] <= '0;
      status_queue.delete();
    end else begin
      if (request.valid && request.ready)
        status_queue.push_back(predict_status(request.cmd, request.rx_byte));
      if (result.valid && result.ready) begin
        results_seen++;
        if (status_queue.size() == 0) begin
          $error("status returned with none outstanding");
          mismatches++;
        end else begin
          want_status = status_queue.pop_front();
          check_field("x_pulse", want_status.x_pulse, result.x_pulse);
          check_field("y_pulse", want_status.y_pulse, result.y_pulse);
          check_field("x_reverse", want_status.x_reverse, result.x_reverse);
          check_field("y_reverse", want_status.y_reverse, result.y_reverse);
          check_field("drive_enable_pin", want_status.drive_enable_pin,
                      result.drive_enable_pin);
          check_field("x_left", want_status.x_left, result.x_left);
          check_field("y_left", want_status.y_left, result.y_left);
          check_field("frame_accepted", want_status.frame_accepted, result.frame_accepted);
          check_field("fault", want_status.fault, result.fault);
        end
      end
    end
  end

endmodule

/* tb/sv/ascii_coord_frame_stepper_driver_tb.sv */
// top of the ascii frame stepper driver testbench: clock, reset, request stimulus, result stalls
// depends on acfsd_pkg, the two channel interfaces, acfsd_status_checker and the block itself
module ascii_coord_frame_stepper_driver_tb;
  import acfsd_pkg::*;

  // the one command code the block leaves unused
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned ITEM_TARGET = 475;  // directed part plus about 450 random
  localparam int unsigned HOLD_CYCLES = 60;

  typedef enum int unsigned {
    FRAME_GOOD,
    FRAME_BAD_SIGN,
    FRAME_BAD_DIGIT,
    FRAME_NO_Y
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst;

  acfsd_in_if  request_ch ();
  acfsd_out_if result_ch ();

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned sent_count = 0;
  bit          steady = 1'b0;     // no idling on either side while set
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic [7:0]  frame_buf [FRAME_LEN];

  ascii_coord_frame_stepper_driver uut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  acfsd_status_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .request      (request_ch),
    .result       (result_ch),
    .mismatches   (mismatches),
    .results_seen (results_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: random stalls, one long hold-off to back the block up into its input
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= 320) begin
      // sender keeps offering requests throughout this stretch
      result_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      result_ch.ready <= steady || ($urandom_range(99) >= 35);
    end
  end

  // offer one request, idling at random first, and return at the edge that takes it
  task automatic send_request(input logic [1:0] c, input logic [7:0] b);
    steady = (sent_count >= 200) && (sent_count < 280);
    while (!steady && $urandom_range(99) < 35) begin
      request_ch.valid <= 1'b0;
      @(posedge clk);
    end
    request_ch.valid   <= 1'b1;
    request_ch.cmd     <= c;
    request_ch.rx_byte <= b;
    do @(posedge clk); while (request_ch.ready !== 1'b1);
    sent_count++;
  endtask

  task automatic send_text(input string text);
    int i;
    for (i = 0; i < text.len(); i++) send_request(CMD_BYTE, text[i]);
  endtask

  // sign and three digits for one axis; counts lean small so ticks can drain them
  task automatic put_axis(input int unsigned at, input bit bad_sign);
    int unsigned count;
    int unsigned pick;
    logic [7:0]  sg;
    pick = $urandom_range(99);
    if (pick < 50)      count = $urandom_range(15);
    else if (pick < 85) count = $urandom_range(99);
    else                count = $urandom_range(999);
    if (bad_sign) begin
      do sg = 8'($urandom_range(255)); while (sg == CH_PLUS || sg == CH_MINUS);
    end else begin
      sg = $urandom_range(1) ? CH_MINUS : CH_PLUS;
    end
    frame_buf[at]   = sg;
    frame_buf[at+1] = CH_ZERO + 8'(count / 100);
    frame_buf[at+2] = CH_ZERO + 8'((count / 10) % 10);
    frame_buf[at+3] = CH_ZERO + 8'(count % 10);
  endtask

  // one ten-byte frame, well-formed or broken in one way, with the odd tick or overrun inside
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned slot;
    frame_kind_t kind;
    logic [7:0]  junk;
    int          i;
    pick = $urandom_range(99);
    if (pick < 60)      kind = FRAME_GOOD;
    else if (pick < 72) kind = FRAME_BAD_SIGN;
    else if (pick < 86) kind = FRAME_BAD_DIGIT;
    else                kind = FRAME_NO_Y;
    frame_buf[0] = CH_X;
    frame_buf[5] = CH_Y;
    put_axis(1, kind == FRAME_BAD_SIGN && $urandom_range(1));
    put_axis(6, (kind == FRAME_BAD_SIGN && frame_buf[1] != CH_PLUS &&
                 frame_buf[1] != CH_MINUS) ? ($urandom_range(1) != 0)
                                           : (kind == FRAME_BAD_SIGN));
    if (kind == FRAME_BAD_DIGIT) begin
      slot = $urandom_range(5);
      slot = (slot < 3) ? slot + 2 : slot + 4;
      do junk = 8'($urandom_range(255)); while (junk >= CH_ZERO && junk <= CH_ZERO + 8'd9);
      frame_buf[slot] = junk;
    end else if (kind == FRAME_NO_Y) begin
      do junk = 8'($urandom_range(255)); while (junk == CH_Y);
      frame_buf[5] = junk;
    end
    for (i = 0; i < FRAME_LEN; i++) begin
      pick = $urandom_range(99);
      if (pick < 4)      send_request(CMD_TICK, 8'($urandom_range(255)));
      else if (pick < 6) send_request(CMD_OVERRUN, 8'($urandom_range(255)));
      send_request(CMD_BYTE, frame_buf[i]);
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned n;
    rst                <= 1'b1;
    request_ch.valid   <= 1'b0;
    request_ch.cmd     <= CMD_BYTE;
    request_ch.rx_byte <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: largest counts with both signs, tick, overrun, unused command,
    // bad sign together with a non-digit, a stray non-start byte and a tick
    send_text("X+999Y-999");
    send_request(CMD_TICK, 8'h00);
    send_request(CMD_OVERRUN, 8'hFF);
    send_request(CMD_UNUSED, 8'h00);
    send_text("X#000Y+0:0");
    send_request(CMD_BYTE, 8'hFF);
    send_request(CMD_TICK, 8'hFF);

    // random: mostly frames with random content, then noise and ticks
    while (sent_count < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_random_frame();
      end else if (pick < 85) begin
        // noise burst, may start a partial frame that later resyncs
        n = $urandom_range(1, 6);
        repeat (n) send_request(CMD_BYTE, 8'($urandom_range(255)));
      end else if (pick < 93) begin
        send_request(CMD_OVERRUN, 8'($urandom_range(255)));
      end else begin
        send_request(CMD_UNUSED, 8'($urandom_range(255)));
      end
      n = $urandom_range(14);
      repeat (n) send_request(CMD_TICK, 8'($urandom_range(255)));
    end
    request_ch.valid <= 1'b0;

    // drain, then keep the clock running so anything unexpected can show up
    wait (results_seen >= sent_count);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("ascii_coord_frame_stepper_driver_tb passed");
    else
      $display("ascii_coord_frame_stepper_driver_tb failed");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("ascii_coord_frame_stepper_driver_tb failed");
    $finish;
  end

endmodule
